>>> hdl/crc8rd_pkg.sv
`timescale 1ns / 1ps
// shared constants, codes, command/status structs and the crc-8 byte function
// for the chunked crc-8 read block; depends on nothing
package crc8rd_pkg;

  // frame size in data bytes, a power of two
  localparam int CHUNK_BYTES = 8;
  localparam int IDX_W       = (CHUNK_BYTES > 1) ? $clog2(CHUNK_BYTES) : 1;
  localparam int CNT_W       = $clog2(CHUNK_BYTES + 1);
  localparam int STEP_W      = $clog2(CHUNK_BYTES + 2);
  localparam int CHUNKS_W    = 16 - $clog2(CHUNK_BYTES);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_READ_CMD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RETRY    = 2'd2;

  // input actions
  localparam logic [1:0] ACT_START = 2'd0;
  localparam logic [1:0] ACT_RECV  = 2'd1;
  localparam logic [1:0] ACT_LINK  = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_TX   = 2'd0;
  localparam logic [1:0] KIND_DATA = 2'd1;
  localparam logic [1:0] KIND_DONE = 2'd2;

  // finish status
  localparam logic [1:0] FIN_OK       = 2'd0;
  localparam logic [1:0] FIN_LINK     = 2'd1;
  localparam logic [1:0] FIN_REJECT   = 2'd2;
  localparam logic [1:0] FIN_TAIL_BAD = 2'd3;

  // crc-8 maxim, contribution of each bit of (crc ^ byte)
  localparam logic [7:0] CRC_TAB [8] = '{
    8'h5e, 8'hbc, 8'h61, 8'hc2, 8'h9d, 8'h23, 8'h46, 8'h8c
  };

  typedef enum logic [3:0] {
    OP_CMD_HI  = 4'd0,
    OP_CMD_LO  = 4'd1,
    OP_ADDR_HI = 4'd2,
    OP_ADDR_LO = 4'd3,
    OP_LEN_HI  = 4'd4,
    OP_LEN_LO  = 4'd5,
    OP_TXCRC   = 4'd6,
    OP_ACK     = 4'd7,
    OP_RETRY   = 4'd8,
    OP_DATA    = 4'd9,
    OP_FINISH  = 4'd10
  } op_t;

  typedef struct packed {
    logic             start;
    logic             gather;
    logic             frame_clear;
    logic             load_chunks;
    logic             dec_chunks;
    logic             emit;
    op_t              op;
    logic [IDX_W-1:0] idx;
    logic [1:0]       fin_status;
    logic             last;
  } dp_cmd_t;

  typedef struct packed {
    logic             emit_ok;
    logic [CNT_W-1:0] byte_count;
    logic             crc_match;
    logic             rx_zero;
    logic             chunks_one;
    logic             len_has_chunks;
    logic [IDX_W-1:0] tail;
  } dp_stat_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] x;
    logic [7:0] r;
    x = crc ^ b;
    r = '0;
    for (int k = 0; k < 8; k++) begin
      if (x[k]) r = r ^ CRC_TAB[k];
    end
    return r;
  endfunction

endpackage

>>> hdl/crc8rd_ctrl.sv
`timescale 1ns / 1ps
// protocol controller: transfer phase, per-word decision and result sequencing
// depends on crc8rd_pkg
module crc8rd_ctrl
  import crc8rd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] action,
  input  dp_stat_t   stat,
  output dp_cmd_t    cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SEND = 2'b10
  } state_t;

  typedef enum logic [4:0] {
    PH_IDLE      = 5'b00001,
    PH_CMD_REPLY = 5'b00010,
    PH_REQ_REPLY = 5'b00100,
    PH_CHUNK     = 5'b01000,
    PH_TAIL      = 5'b10000
  } phase_t;

  typedef enum logic [2:0] {
    J_TXCMD = 3'd0,
    J_TXREQ = 3'd1,
    J_FIN   = 3'd2,
    J_GOOD  = 3'd3,
    J_BAD   = 3'd4
  } job_t;

  state_t           state, state_next;
  phase_t           phase, phase_next;
  job_t             job, job_new;
  logic [STEP_W-1:0] step, step_next;
  logic [CNT_W-1:0] data_n, n_new;
  logic             fin, fin_new;
  logic [1:0]       fin_status, status_new;
  logic             launch;
  logic             in_fire;

  assign in_stall = (state != S_IDLE);
  assign in_fire  = in_valid && !in_stall;

  always_comb begin
    cmd        = '0;
    cmd.op     = OP_FINISH;
    launch     = 1'b0;
    job_new    = J_FIN;
    n_new      = '0;
    fin_new    = 1'b0;
    status_new = FIN_OK;
    phase_next = phase;
    state_next = state;
    step_next  = step;

    // decision on an accepted word
    if (in_fire) begin
      case (action)
        ACT_START: begin
          if (phase == PH_IDLE) begin
            cmd.start  = 1'b1;
            launch     = 1'b1;
            job_new    = J_TXCMD;
            phase_next = PH_CMD_REPLY;
          end
        end
        ACT_LINK: begin
          if (phase != PH_IDLE) begin
            launch     = 1'b1;
            job_new    = J_FIN;
            status_new = FIN_LINK;
            phase_next = PH_IDLE;
          end
        end
        ACT_RECV: begin
          case (phase)
            PH_CMD_REPLY: begin
              launch     = 1'b1;
              job_new    = J_TXREQ;
              phase_next = PH_REQ_REPLY;
            end
            PH_REQ_REPLY: begin
              launch = 1'b1;
              if (!stat.rx_zero) begin
                job_new    = J_FIN;
                status_new = FIN_REJECT;
                phase_next = PH_IDLE;
              end else begin
                job_new         = J_GOOD;
                cmd.load_chunks = 1'b1;
                cmd.frame_clear = 1'b1;
                if (stat.len_has_chunks) begin
                  phase_next = PH_CHUNK;
                end else if (stat.tail != '0) begin
                  phase_next = PH_TAIL;
                end else begin
                  fin_new    = 1'b1;
                  phase_next = PH_IDLE;
                end
              end
            end
            PH_CHUNK: begin
              if (stat.byte_count < CNT_W'(CHUNK_BYTES)) begin
                cmd.gather = 1'b1;
              end else begin
                cmd.frame_clear = 1'b1;
                launch          = 1'b1;
                if (stat.crc_match) begin
                  job_new        = J_GOOD;
                  n_new          = CNT_W'(CHUNK_BYTES);
                  cmd.dec_chunks = 1'b1;
                  if (stat.chunks_one) begin
                    if (stat.tail != '0) begin
                      phase_next = PH_TAIL;
                    end else begin
                      fin_new    = 1'b1;
                      phase_next = PH_IDLE;
                    end
                  end
                end else begin
                  job_new = J_BAD;
                end
              end
            end
            PH_TAIL: begin
              if (stat.byte_count < CNT_W'(stat.tail)) begin
                cmd.gather = 1'b1;
              end else begin
                cmd.frame_clear = 1'b1;
                launch          = 1'b1;
                fin_new         = 1'b1;
                phase_next      = PH_IDLE;
                if (stat.crc_match) begin
                  job_new = J_GOOD;
                  n_new   = CNT_W'(stat.tail);
                end else begin
                  job_new    = J_BAD;
                  status_new = FIN_TAIL_BAD;
                end
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
      if (launch) begin
        state_next = S_SEND;
        step_next  = '0;
      end
    end

    // one result per cycle while the output register can take it
    if (state == S_SEND && stat.emit_ok) begin
      cmd.emit       = 1'b1;
      cmd.idx        = step[IDX_W-1:0];
      cmd.fin_status = fin_status;
      case (job)
        J_TXCMD: begin
          case (step)
            STEP_W'(0): cmd.op = OP_CMD_HI;
            STEP_W'(1): cmd.op = OP_CMD_LO;
            default:    cmd.op = OP_TXCRC;
          endcase
          cmd.last = (step == STEP_W'(2));
        end
        J_TXREQ: begin
          case (step)
            STEP_W'(0): cmd.op = OP_ADDR_HI;
            STEP_W'(1): cmd.op = OP_ADDR_LO;
            STEP_W'(2): cmd.op = OP_LEN_HI;
            STEP_W'(3): cmd.op = OP_LEN_LO;
            default:    cmd.op = OP_TXCRC;
          endcase
          cmd.last = (step == STEP_W'(4));
        end
        J_GOOD: begin
          if (step < STEP_W'(data_n)) begin
            cmd.op = OP_DATA;
          end else if (step == STEP_W'(data_n)) begin
            cmd.op   = OP_ACK;
            cmd.last = !fin;
          end else begin
            cmd.op   = OP_FINISH;
            cmd.last = 1'b1;
          end
        end
        J_BAD: begin
          if (step == '0) begin
            cmd.op   = OP_RETRY;
            cmd.last = !fin;
          end else begin
            cmd.op   = OP_FINISH;
            cmd.last = 1'b1;
          end
        end
        default: begin
          cmd.op   = OP_FINISH;
          cmd.last = 1'b1;
        end
      endcase
      if (cmd.last) begin
        state_next = S_IDLE;
        step_next  = '0;
      end else begin
        step_next = step + STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      phase      <= PH_IDLE;
      step       <= '0;
      job        <= J_FIN;
      data_n     <= '0;
      fin        <= 1'b0;
      fin_status <= FIN_OK;
    end else begin
      state <= state_next;
      phase <= phase_next;
      step  <= step_next;
      if (launch) begin
        job        <= job_new;
        data_n     <= n_new;
        fin        <= fin_new;
        fin_status <= status_new;
      end
    end
  end

  a_idle_recv_silent: assert property (@(posedge clk) disable iff (rst)
    in_fire && action == ACT_RECV && phase == PH_IDLE |=> state == S_IDLE)
    else $error("receive while idle started a result sequence");

  a_last_ends_job: assert property (@(posedge clk) disable iff (rst)
    cmd.emit && cmd.last |=> state == S_IDLE)
    else $error("sequence went on after its final result");

  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_SEND |-> step <= STEP_W'(CHUNK_BYTES + 1))
    else $error("result step ran past the longest sequence");

  a_link_abort: assert property (@(posedge clk) disable iff (rst)
    in_fire && action == ACT_LINK && phase != PH_IDLE |=>
      phase == PH_IDLE && state == S_SEND)
    else $error("link error while busy did not abort");

endmodule

>>> hdl/crc8rd_dp.sv
`timescale 1ns / 1ps
// datapath: config registers, request latches, chunk store, crc units, counters
// and the result register; depends on crc8rd_pkg
module crc8rd_dp
  import crc8rd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [15:0]           start_address,
  input  logic [15:0]           transfer_length,
  input  logic [7:0]            received_byte,
  input  dp_cmd_t               cmd,
  output dp_stat_t              stat,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            kind,
  output logic [7:0]            byte_value,
  output logic [15:0]           data_offset,
  output logic [1:0]            status,
  output logic                  last
);

  logic [15:0]         read_cmd;
  logic [7:0]          ack_code;
  logic [7:0]          retry_code;
  logic [15:0]         address_latch;
  logic [15:0]         length_latch;
  logic [CHUNKS_W-1:0] chunks_left;
  logic [15:0]         delivered_offset;
  logic [CNT_W-1:0]    byte_count;
  logic [7:0]          running_crc;
  logic [7:0]          tx_crc;
  logic [7:0]          chunk_store [CHUNK_BYTES];
  logic [7:0]          sel_byte;

  assign stat.emit_ok        = !out_valid || !out_stall;
  assign stat.byte_count     = byte_count;
  assign stat.crc_match      = (received_byte == running_crc);
  assign stat.rx_zero        = (received_byte == 8'd0);
  assign stat.chunks_one     = (chunks_left == CHUNKS_W'(1));
  assign stat.len_has_chunks = ((length_latch >> IDX_W) != 16'd0);
  assign stat.tail           = length_latch[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      read_cmd   <= '0;
      ack_code   <= 8'd0;
      retry_code <= 8'd1;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_READ_CMD: read_cmd   <= cfg_data[15:0];
        CFG_ACK:      ack_code   <= cfg_data[7:0];
        CFG_RETRY:    retry_code <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cmd.op)
      OP_CMD_HI:  sel_byte = read_cmd[15:8];
      OP_CMD_LO:  sel_byte = read_cmd[7:0];
      OP_ADDR_HI: sel_byte = address_latch[15:8];
      OP_ADDR_LO: sel_byte = address_latch[7:0];
      OP_LEN_HI:  sel_byte = length_latch[15:8];
      OP_LEN_LO:  sel_byte = length_latch[7:0];
      OP_TXCRC:   sel_byte = tx_crc;
      OP_ACK:     sel_byte = ack_code;
      OP_RETRY:   sel_byte = retry_code;
      OP_DATA:    sel_byte = chunk_store[cmd.idx];
      default:    sel_byte = 8'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      address_latch    <= '0;
      length_latch     <= '0;
      chunks_left      <= '0;
      delivered_offset <= '0;
      byte_count       <= '0;
      running_crc      <= '0;
      tx_crc           <= '0;
    end else begin
      if (cmd.start) begin
        address_latch    <= start_address;
        length_latch     <= transfer_length;
        delivered_offset <= '0;
        chunks_left      <= '0;
      end
      if (cmd.load_chunks) begin
        chunks_left <= CHUNKS_W'(length_latch >> IDX_W);
      end else if (cmd.dec_chunks && chunks_left != '0) begin
        chunks_left <= chunks_left - CHUNKS_W'(1);
      end
      if (cmd.start || cmd.frame_clear) begin
        byte_count  <= '0;
        running_crc <= '0;
      end else if (cmd.gather) begin
        byte_count  <= byte_count + CNT_W'(1);
        running_crc <= crc8_byte(running_crc, received_byte);
      end
      if (cmd.emit) begin
        // header crc runs over transmitted frame bytes, cleared once sent
        if (cmd.op inside {OP_CMD_HI, OP_CMD_LO, OP_ADDR_HI, OP_ADDR_LO,
                           OP_LEN_HI, OP_LEN_LO}) begin
          tx_crc <= crc8_byte(tx_crc, sel_byte);
        end else if (cmd.op == OP_TXCRC) begin
          tx_crc <= '0;
        end
        if (cmd.op == OP_DATA) begin
          delivered_offset <= delivered_offset + 16'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.gather) begin
      chunk_store[byte_count[IDX_W-1:0]] <= received_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      byte_value  <= sel_byte;
      last        <= cmd.last;
      data_offset <= (cmd.op == OP_DATA) ? delivered_offset : 16'd0;
      status      <= (cmd.op == OP_FINISH) ? cmd.fin_status : FIN_OK;
      case (cmd.op)
        OP_DATA:   kind <= KIND_DATA;
        OP_FINISH: kind <= KIND_DONE;
        default:   kind <= KIND_TX;
      endcase
    end
  end

endmodule

>>> hdl/chunked_read_crc8_ack_retry.sv
`timescale 1ns / 1ps
// top level of the chunked crc-8 read host: controller plus datapath
// depends on crc8rd_pkg, crc8rd_ctrl, crc8rd_dp
//
//  channel  | handshake               | payload
//  ---------+-------------------------+---------------------------------------------
//  input    | in_valid / in_stall     | action, start_address, transfer_length,
//           |                         | received_byte
//  output   | out_valid / out_stall   | kind, byte_value, data_offset, status, last
//  config   | cfg_write               | cfg_index, cfg_data
//
// an accepted word that causes results holds the input until its last result is issued;
// gathered data bytes cause no result and leave the input free; the controller fills
// the single result register one word a cycle while the output side keeps up
// in_stall is high while a result sequence is being issued; out_stall holds the
// result register and pauses the sequence without losing a word
// rst is synchronous, active high: phase idle, counters and crcs zero, ack code 0,
// retry code 1, read command 0; the chunk store holds no reset value
module chunked_read_crc8_ack_retry
  import crc8rd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // configuration
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // input words
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            action,
  input  logic [15:0]           start_address,
  input  logic [15:0]           transfer_length,
  input  logic [7:0]            received_byte,
  // result words
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            kind,
  output logic [7:0]            byte_value,
  output logic [15:0]           data_offset,
  output logic [1:0]            status,
  output logic                  last
);

  // controller commands the datapath, datapath reports counters and compares
  dp_cmd_t  cmd;
  dp_stat_t stat;

  crc8rd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .action   (action),
    .stat     (stat),
    .cmd      (cmd)
  );

  // holds the chunk store, both crc registers and the result register
  crc8rd_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .start_address   (start_address),
    .transfer_length (transfer_length),
    .received_byte   (received_byte),
    .cmd             (cmd),
    .stat            (stat),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .kind            (kind),
    .byte_value      (byte_value),
    .data_offset     (data_offset),
    .status          (status),
    .last            (last)
  );

endmodule
